FILE: rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package u8u16_pkg;

    // One request on the byte side.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } byte_req_t;

    // One request on the code unit side.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        item_done;
        logic        text_done;
    } unit_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic pop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic res_empty;
        logic res_last;
    } status_t;

    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [20:0] SUPPLEMENTARY = 21'h10000;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [15:0] LOW_SURR      = 16'hDC00;

endpackage

`default_nettype wire

FILE: rtl/core/u8u16_ctrl.sv
// Controller state machine of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg for the state, command and status types.
`default_nettype none

module u8u16_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    output logic                    unit_valid,
    input  wire logic               unit_ready,
    output u8u16_pkg::cmd_t         cmd,
    input  wire u8u16_pkg::status_t sts
);
    import u8u16_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        byte_ready = 1'b0;
        unit_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                byte_ready = 1'b1;
                if (byte_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.res_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    unit_valid = 1'b1;
                    if (unit_ready)
                    begin
                        cmd.pop = 1'b1;
                        if (sts.res_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/u8u16_datapath.sv
// Datapath of the UTF-8 to UTF-16 transcoder: byte buffer, decoder and result queue.
// Depends on u8u16_pkg for the request, command and status types and constants.
`default_nettype none

module u8u16_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire u8u16_pkg::cmd_t      cmd,
    output u8u16_pkg::status_t        sts,
    input  wire u8u16_pkg::byte_req_t byte_data,
    output u8u16_pkg::unit_req_t      unit_data
);
    import u8u16_pkg::*;

    // Byte buffer: held bytes of an open sequence plus the newest byte.
    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  pos_reg, pos_next;
    logic        fin_reg, fin_next;

    // Result queue for the code units of one byte.
    logic [15:0] res_reg [4];
    logic [2:0]  res_cnt_reg, res_cnt_next;
    logic [1:0]  rd_reg, rd_next;

    logic [7:0]  lead, c1, c2, c3;
    logic [1:0]  extra;
    logic        lead_ok;
    logic        cont_ok;
    logic        incomplete;
    logic [2:0]  end_pos;
    logic [20:0] cp;
    logic [20:0] offset;
    logic [1:0]  push_n;
    logic [15:0] unit0, unit1;
    logic        buf_wr;
    logic [1:0]  ix0, ix1;
    logic        scan_done;

    assign lead = buf_reg[pos_reg[1:0]];
    assign c1   = buf_reg[pos_reg[1:0] + 2'd1];
    assign c2   = buf_reg[pos_reg[1:0] + 2'd2];
    assign c3   = buf_reg[pos_reg[1:0] + 2'd3];

    always_comb
    begin
        lead_ok = 1'b1;
        extra   = 2'd0;
        cp      = '0;
        if (!lead[7])
        begin
            cp = {14'd0, lead[6:0]};
        end
        else if (lead[7:5] == 3'b110)
        begin
            extra = 2'd1;
            cp    = {10'd0, lead[4:0], c1[5:0]};
        end
        else if (lead[7:4] == 4'b1110)
        begin
            extra = 2'd2;
            cp    = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
        end
        else if (lead[7:3] == 5'b11110)
        begin
            extra = 2'd3;
            cp    = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
        end
        else
        begin
            lead_ok = 1'b0;
        end
    end

    // Only the continuation bytes the lead calls for are checked.
    assign cont_ok = (c1[7:6] == 2'b10)
                     && ((extra < 2'd2) || (c2[7:6] == 2'b10))
                     && ((extra < 2'd3) || (c3[7:6] == 2'b10));
    assign end_pos    = pos_reg + {1'b0, extra};
    assign incomplete = (end_pos >= cnt_reg);
    assign offset     = cp - SUPPLEMENTARY;

    always_comb
    begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        fin_next     = fin_reg;
        res_cnt_next = res_cnt_reg;
        rd_next      = rd_reg;
        push_n       = 2'd0;
        unit0        = REPLACEMENT;
        unit1        = REPLACEMENT;
        buf_wr       = 1'b0;
        scan_done    = 1'b0;

        if (cmd.load)
        begin
            buf_next[cnt_reg[1:0]] = byte_data.text_byte;
            buf_wr       = 1'b1;
            cnt_next     = cnt_reg + 3'd1;
            fin_next     = byte_data.final_byte;
            pos_next     = '0;
            res_cnt_next = '0;
            rd_next      = '0;
        end
        else if (cmd.scan)
        begin
            if (pos_reg >= cnt_reg)
            begin
                scan_done = 1'b1;
                cnt_next  = '0;
            end
            else if (!lead_ok)
            begin
                push_n   = 2'd1;
                pos_next = pos_reg + 3'd1;
            end
            else if (extra == 2'd0)
            begin
                push_n   = 2'd1;
                unit0    = cp[15:0];
                pos_next = pos_reg + 3'd1;
            end
            else if (incomplete)
            begin
                scan_done = 1'b1;
                if (fin_reg)
                begin
                    push_n   = 2'd1;
                    cnt_next = '0;
                end
                else
                begin
                    // Keep the open sequence, moved down to the front.
                    for (int k = 0; k < 4; k++)
                    begin
                        buf_next[k] = buf_reg[pos_reg[1:0] + k[1:0]];
                    end
                    buf_wr   = 1'b1;
                    cnt_next = cnt_reg - pos_reg;
                end
            end
            else if (!cont_ok)
            begin
                // Replacement for the lead, then rescan from the next byte.
                push_n   = 2'd1;
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                pos_next = end_pos + 3'd1;
                if (cp[20:16] != 5'd0)
                begin
                    push_n = 2'd2;
                    unit0  = HIGH_SURR + {5'd0, offset[20:10]};
                    unit1  = LOW_SURR + {6'd0, offset[9:0]};
                end
                else
                begin
                    push_n = 2'd1;
                    unit0  = cp[15:0];
                end
            end
            res_cnt_next = res_cnt_reg + {1'b0, push_n};
        end
        else if (cmd.pop)
        begin
            rd_next = rd_reg + 2'd1;
        end
    end

    assign ix0 = res_cnt_reg[1:0];
    assign ix1 = res_cnt_reg[1:0] + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pos_reg     <= '0;
            fin_reg     <= 1'b0;
            res_cnt_reg <= '0;
            rd_reg      <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            fin_reg     <= fin_next;
            res_cnt_reg <= res_cnt_next;
            rd_reg      <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            buf_reg <= buf_next;
        end
        if (push_n != 2'd0)
        begin
            res_reg[ix0] <= unit0;
        end
        if (push_n == 2'd2)
        begin
            res_reg[ix1] <= unit1;
        end
    end

    assign sts.scan_done = scan_done;
    assign sts.res_empty = (res_cnt_reg == 3'd0);
    assign sts.res_last  = ({1'b0, rd_reg} + 3'd1 == res_cnt_reg);

    assign unit_data.code_unit = res_reg[rd_reg];
    assign unit_data.item_done = sts.res_last;
    assign unit_data.text_done = sts.res_last && fin_reg;

endmodule

`default_nettype wire

FILE: rtl/core/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u8u16_ctrl and u8u16_datapath; depends on u8u16_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   byte      in         byte_valid / byte_ready   byte_data (text_byte, final_byte)
//   unit      out        unit_valid / unit_ready   unit_data (code_unit, item_done, text_done)
//
// Each byte request is loaded, then scanned, decoding one character or rejecting
// one byte per scan step up to a closing scan step, then drained one code unit
// per handshake (the drain state passes straight to idle when the byte yields nothing).
// Reset clears the byte count, scan position and result queue at once.
// While unit_ready is low the current code unit holds and no new byte is taken.
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_ready,
    input  wire u8u16_pkg::byte_req_t byte_data,
    output logic                      unit_valid,
    input  wire logic                 unit_ready,
    output u8u16_pkg::unit_req_t      unit_data
);
    import u8u16_pkg::*;

    // Commands flow from the controller into the datapath; status flows back.
    cmd_t    cmd;
    status_t sts;

    // The controller owns the handshakes and sequences load, scan and drain.
    u8u16_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // The datapath holds the open sequence, decodes it and queues the units.
    u8u16_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .byte_data (byte_data),
        .unit_data (unit_data)
    );

endmodule

`default_nettype wire

FILE: sim/utf8_to_utf16_transcoder_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder top level.
// Drives byte requests, predicts code units with its own decoder, checks every unit request.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder.
module utf8_to_utf16_transcoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    // Margin for the block to finish its scan and drain steps and return to idle.
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD = 400;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_ready;
    byte_req_t byte_data;
    logic      unit_valid;
    logic      unit_ready;
    unit_req_t unit_data;

    utf8_to_utf16_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decoder state of the predictor: the bytes of the sequence still being collected.
    logic [7:0] pend_bytes [4];
    int unsigned pend_count = 0;

    // Code units the block owes us, oldest first.
    unit_req_t expected_units [$];

    // The text under construction for the sender, lead bytes first.
    logic [7:0] text_buf [$];

    int mismatches = 0;
    int bytes_taken = 0;
    int units_checked = 0;
    int texts_sent = 0;

    // Idle percentages for the two sides, and a long receiver hold-off in cycles.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left = 0;

    function automatic unit_req_t make_unit(input logic [15:0] value);
        unit_req_t u;
        u.code_unit = value;
        u.item_done = 1'b0;
        u.text_done = 1'b0;
        return u;
    endfunction

    // Works out the code units one accepted byte request releases and queues them.
    // The held bytes plus the new byte are scanned from the start; an incomplete
    // sequence at the tail is held back unless the text ends here.
    task automatic predict_units(input byte_req_t req);
        logic [7:0]  seq [4];
        int unsigned cnt;
        int unsigned pos;
        int unsigned extra;
        int unsigned k;
        logic [31:0] cp;
        logic        lead_ok;
        logic        cont_ok;
        unit_req_t   fresh [$];

        cnt = pend_count;
        for (k = 0; k < cnt; k++)
        begin
            seq[k] = pend_bytes[k];
        end
        seq[cnt] = req.text_byte;
        cnt++;
        pos = 0;

        while (pos < cnt)
        begin
            lead_ok = 1'b1;
            extra = 0;
            cp = '0;
            casez (seq[pos])
                8'b0???????: cp = {24'd0, seq[pos]};
                8'b110?????:
                begin
                    extra = 1;
                    cp = {27'd0, seq[pos][4:0]};
                end
                8'b1110????:
                begin
                    extra = 2;
                    cp = {28'd0, seq[pos][3:0]};
                end
                8'b11110???:
                begin
                    extra = 3;
                    cp = {29'd0, seq[pos][2:0]};
                end
                default: lead_ok = 1'b0;
            endcase

            if (!lead_ok)
            begin
                // Stray continuation or a lead beyond F7.
                fresh = {fresh, make_unit(REPLACEMENT)};
                pos++;
            end
            else if (extra == 0)
            begin
                fresh = {fresh, make_unit(cp[15:0])};
                pos++;
            end
            else if (pos + extra >= cnt)
            begin
                // Not all continuation bytes are here yet.
                if (req.final_byte)
                begin
                    fresh = {fresh, make_unit(REPLACEMENT)};
                    pos = cnt;
                end
                break;
            end
            else
            begin
                cont_ok = 1'b1;
                for (k = 1; k <= extra; k++)
                begin
                    if (seq[pos + k][7:6] != 2'b10)
                    begin
                        cont_ok = 1'b0;
                    end
                    cp = {cp[25:0], seq[pos + k][5:0]};
                end
                if (!cont_ok)
                begin
                    // Reject the lead only; the bytes after it are scanned again.
                    fresh = {fresh, make_unit(REPLACEMENT)};
                    pos++;
                end
                else
                begin
                    pos += extra + 1;
                    if (cp <= 32'h0000_FFFF)
                    begin
                        fresh = {fresh, make_unit(cp[15:0])};
                    end
                    else
                    begin
                        cp = cp - {11'd0, SUPPLEMENTARY};
                        fresh = {fresh, make_unit(HIGH_SURR + {5'd0, cp[20:10]})};
                        fresh = {fresh, make_unit(LOW_SURR + {6'd0, cp[9:0]})};
                    end
                end
            end
        end

        if (req.final_byte || pos >= cnt)
        begin
            pend_count = 0;
        end
        else
        begin
            for (k = 0; k < cnt - pos; k++)
            begin
                pend_bytes[k] = seq[pos + k];
            end
            pend_count = cnt - pos;
        end

        if (fresh.size() > 0)
        begin
            fresh[fresh.size() - 1].item_done = 1'b1;
            if (req.final_byte)
            begin
                fresh[fresh.size() - 1].text_done = 1'b1;
            end
        end
        expected_units = {expected_units, fresh};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Scoreboard. A new byte request is predicted before any unit of the same edge is
    // checked, so a unit can never arrive ahead of its expectation in this process.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                predict_units(byte_data);
                bytes_taken++;
            end
            if (unit_valid && unit_ready)
            begin
                if (expected_units.size() == 0)
                begin
                    report_mismatch("unexpected code unit", unit_data.code_unit, 0);
                end
                else
                begin
                    unit_req_t want;
                    want = expected_units.pop_front();
                    if (unit_data.code_unit !== want.code_unit)
                    begin
                        report_mismatch("code_unit", unit_data.code_unit, want.code_unit);
                    end
                    if (unit_data.item_done !== want.item_done)
                    begin
                        report_mismatch("item_done", unit_data.item_done, want.item_done);
                    end
                    if (unit_data.text_done !== want.text_done)
                    begin
                        report_mismatch("text_done", unit_data.text_done, want.text_done);
                    end
                end
                units_checked++;
            end
        end
    end

    // Receiver: random idling, or a long hold-off when one has been asked for.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            unit_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            unit_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            unit_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one byte request, with a random gap in front, and returns once it is taken.
    task automatic send_byte(input logic [7:0] value, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_data.text_byte <= value;
        byte_data.final_byte <= last;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (!byte_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Sends the text in text_buf with the final flag on its last byte.
    task automatic send_text();
        foreach (text_buf[i])
        begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic release_valid();
        @(negedge clk);
        byte_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_valid();
        while (expected_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Builds a text that is mostly well-formed characters with random content,
    // salted with stray bytes, broken sequences and the odd cut-off tail.
    task automatic build_random_text();
        int chars;
        int r;
        int n;
        chars = $urandom_range(1, 10);
        for (int c = 0; c < chars; c++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                text_buf = {text_buf, 8'($urandom_range(0, 127))};
            end
            else if (r < 48)
            begin
                text_buf = {text_buf, 8'($urandom_range(8'hC0, 8'hDF))};
                text_buf = {text_buf, cont_byte()};
            end
            else if (r < 63)
            begin
                text_buf = {text_buf, 8'($urandom_range(8'hE0, 8'hEF))};
                text_buf = {text_buf, cont_byte()};
                text_buf = {text_buf, cont_byte()};
            end
            else if (r < 80)
            begin
                text_buf = {text_buf, 8'($urandom_range(8'hF0, 8'hF7))};
                text_buf = {text_buf, cont_byte()};
                text_buf = {text_buf, cont_byte()};
                text_buf = {text_buf, cont_byte()};
            end
            else if (r < 88)
            begin
                text_buf = {text_buf, 8'($urandom_range(0, 255))};
            end
            else if (r < 96)
            begin
                // A lead, up to two continuation bytes, and then a byte that is not a continuation byte.
                n = $urandom_range(1, 3);
                text_buf = {text_buf, 8'($urandom_range(8'hC0, 8'hF7))};
                for (int k = 1; k < n; k++)
                begin
                    text_buf = {text_buf, cont_byte()};
                end
                text_buf = {text_buf, (8'($urandom_range(0, 255)) & 8'hBF | 8'h40)};
            end
            else
            begin
                // A lead with too few continuation bytes left before the text ends.
                text_buf = {text_buf, 8'($urandom_range(8'hE0, 8'hF7))};
                if ($urandom_range(0, 1) == 1)
                begin
                    text_buf = {text_buf, cont_byte()};
                end
                break;
            end
        end
    endtask

    // Extremes of the one-byte range and one character of each length, the largest
    // four-byte sequence among them.
    task automatic test_well_formed();
        text_buf = {8'h00};
        send_text();
        text_buf = {8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        text_buf = {8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        wait_drained();
    endtask

    // Invalid leads, a lead whose continuation bytes are plain ASCII, and a
    // sequence cut short by the end of the text.
    task automatic test_error_cases();
        text_buf = {8'h80, 8'hBF, 8'hF8, 8'hFF};
        send_text();
        text_buf = {8'hF0, 8'h41, 8'h42, 8'h43};
        send_text();
        text_buf = {8'hE2, 8'h82};
        send_text();
        wait_drained();
    endtask

    task automatic test_random_texts(input int send_pct, input int recv_pct, input int target);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_taken;
        while (bytes_taken - start < target)
        begin
            build_random_text();
            send_text();
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the block has to stall its byte side.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        stall_left = LONG_HOLD;
        for (int t = 0; t < 4; t++)
        begin
            build_random_text();
            send_text();
        end
        wait_drained();
    endtask

    // The sender pauses mid-text until every owed unit has come out, then goes on.
    task automatic test_drain_pause();
        send_idle_pct = 18;
        recv_idle_pct = 18;
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        wait_drained();
        send_byte(8'hAC, 1'b0);
        wait_drained();
        send_byte(8'h41, 1'b1);
        texts_sent++;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_data = '0;
        unit_ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 70;
        test_well_formed();
        test_error_cases();
        test_random_texts(18, 70, 30);
        test_random_texts(70, 18, 30);
        test_random_texts(0, 0, 30);
        test_backpressure();
        test_drain_pause();

        $display("Checked %0d code units from %0d bytes in %0d texts.",
                 units_checked, bytes_taken, texts_sent);
        $display("Covered all lead classes, replacements, surrogate pairs and long stalls.");
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d code units still owed.", expected_units.size());
        $display("status: fail");
        $finish;
    end

endmodule
